// ===== hdl/hbpa_pkg.sv =====
package hbpa_pkg;

    localparam int MAX_PAGES   = 262144;
    localparam int MAX_LEVELS  = 4;
    localparam int WORD_W      = 64;
    localparam int BIT_SEL_W   = 6;
    localparam int PAGE_W      = 18;
    localparam int CNT_W       = 19;
    localparam int STORE_WORDS = MAX_PAGES / 64 + MAX_PAGES / 4096 + MAX_PAGES / 262144
                                 + 2 * MAX_LEVELS + 2;
    localparam int IDX_W       = $clog2(STORE_WORDS);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int LCNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int WIDTH_W     = $clog2(WORD_W + 1);

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_FREE    = 2'd1,
        KIND_RESERVE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_FREE = 2'd1,
        STATUS_RANGE   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_EV,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PAGE_W-1:0] page_number;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] granted_page;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]                     eff_pages;
        logic [LCNT_W-1:0]                    level_count;
        logic [MAX_LEVELS-1:0][IDX_W-1:0]     base;
        logic [MAX_LEVELS-1:0][WIDTH_W-1:0]   width;
    } geom_t;

    typedef struct packed {
        logic                 any_free;
        logic [BIT_SEL_W-1:0] first_free;
        logic [WORD_W-1:0]    set_word;
        logic [WORD_W-1:0]    clr_word;
        logic                 bit_set;
        logic                 set_full;
    } word_res_t;

endpackage

// ===== hdl/hbpa_geom.sv =====
module hbpa_geom (
    input  logic                      aclk,
    input  logic [hbpa_pkg::CNT_W-1:0] managed_pages,
    output hbpa_pkg::geom_t           geom
);
    import hbpa_pkg::*;

    geom_t geom_next;
    geom_t geom_reg;

    always_comb begin
        logic [CNT_W:0]  m;
        logic [CNT_W:0]  sz;
        logic [CNT_W:0]  bits [MAX_LEVELS];
        logic            stop;
        geom_next = '0;
        sz = '0;
        m = {1'b0, managed_pages};
        if (m == '0) m = (CNT_W+1)'(1);
        if (m > (CNT_W+1)'(MAX_PAGES)) m = (CNT_W+1)'(MAX_PAGES);
        geom_next.eff_pages = m[CNT_W-1:0];
        for (int i = 0; i < MAX_LEVELS; i++) bits[i] = '0;
        bits[0] = ((m + (CNT_W+1)'(63)) >> 6) << 6;
        geom_next.level_count = LCNT_W'(1);
        stop = 1'b0;
        for (int i = 0; i < MAX_LEVELS - 1; i++) begin
            if (!stop && bits[i] > (CNT_W+1)'(WORD_W)) begin
                sz = bits[i] >> 6;
                if (sz > (CNT_W+1)'(WORD_W)) sz = ((sz + (CNT_W+1)'(63)) >> 6) << 6;
                geom_next.base[i+1] = geom_next.base[i]
                                      + IDX_W'((bits[i] + (CNT_W+1)'(63)) >> 6);
                bits[i+1] = sz;
                geom_next.level_count = geom_next.level_count + LCNT_W'(1);
            end else begin
                stop = 1'b1;
            end
        end
        for (int i = 0; i < MAX_LEVELS; i++) begin
            geom_next.width[i] = (bits[i] >= (CNT_W+1)'(WORD_W)) ? WIDTH_W'(WORD_W)
                                                                : bits[i][WIDTH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;

endmodule

// ===== hdl/hbpa_word_unit.sv =====
module hbpa_word_unit (
    input  logic [hbpa_pkg::WORD_W-1:0]    word,
    input  logic [hbpa_pkg::BIT_SEL_W-1:0] bit_sel,
    input  logic [hbpa_pkg::WIDTH_W-1:0]   width,
    output hbpa_pkg::word_res_t           res
);
    import hbpa_pkg::*;

    always_comb begin
        logic [WORD_W-1:0] free_bits;
        logic [WORD_W-1:0] mask;
        free_bits = ~word;
        if (width < WIDTH_W'(WORD_W)) begin
            free_bits = free_bits & ((WORD_W'(1) << width[BIT_SEL_W-1:0]) - WORD_W'(1));
        end
        mask = WORD_W'(1) << bit_sel;
        res.any_free   = |free_bits;
        res.first_free = '0;
        // lowest clear bit wins: scan from the top down
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) res.first_free = BIT_SEL_W'(b);
        end
        res.set_word = word | mask;
        res.clr_word = word & ~mask;
        res.bit_set  = |(word & mask);
        res.set_full = &(word | mask);
    end

endmodule

// ===== hdl/hierarchical_bitmap_page_allocator.sv =====
// Channel   Ports                          Direction  Payload
// s_        s_valid, s_ready, s_item       in         kind, page_number
// m_        m_valid, m_ready, m_item       out        status, granted_page
// cfg_      cfg_valid, cfg_ready, cfg_data in         managed_pages
//
// One item at a time through a read/modify/write sequencer on a single-port
// word store. Each level takes a read step and an evaluate/write step through the
// shared word unit: allocate searches down the levels and then marks back up,
// free or reserve only marks, and range errors and unused kinds go straight to done.
// After reset a clearing pass sets all STORE_WORDS words to ones
// with s_ready low; configuration writes are taken only while idle, and
// s_ready stays low while one is offered and in the cycle after it is taken.
// The result sits in an output register, so a stalled m_ready holds only the
// finished item and the next item waits in the final sequencer state.
module hierarchical_bitmap_page_allocator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  hbpa_pkg::in_item_t         s_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output hbpa_pkg::out_item_t        m_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hbpa_pkg::CNT_W-1:0] cfg_data
);
    import hbpa_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  managed_pages_reg, managed_pages_next;
    logic              cfg_wait_reg, cfg_wait_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [PAGE_W-1:0] pos_reg, pos_next;
    logic              set_mode_reg, set_mode_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    // word store
    logic [WORD_W-1:0] mem [STORE_WORDS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_oob_reg;
    logic              mem_we, mem_re;
    logic [IDX_W-1:0]  mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    geom_t             geom;
    word_res_t         wres;
    logic [WORD_W-1:0] cur_word;
    logic [ADDR_W-1:0] lvl_addr;
    logic              lvl_addr_ok;
    logic [LVL_W-1:0]  top_lvl;
    logic              last_lvl;
    logic [PAGE_W-1:0] found_pos;
    logic              accept;
    logic              cfg_accept;

    hbpa_geom u_geom (
        .aclk          (aclk),
        .managed_pages (managed_pages_reg),
        .geom          (geom)
    );

    hbpa_word_unit u_word (
        .word    (cur_word),
        .bit_sel (pos_reg[BIT_SEL_W-1:0]),
        .width   (geom.width[lvl_reg]),
        .res     (wres)
    );

    // an address past the store reads as all ones and drops writes
    assign cur_word    = rd_oob_reg ? '1 : rd_data_reg;
    assign lvl_addr    = {1'b0, geom.base[lvl_reg]} + ADDR_W'(pos_reg[PAGE_W-1:BIT_SEL_W]);
    assign lvl_addr_ok = lvl_addr < ADDR_W'(STORE_WORDS);
    assign top_lvl     = LVL_W'(geom.level_count - LCNT_W'(1));
    assign last_lvl    = (LCNT_W'(lvl_reg) + LCNT_W'(1)) >= geom.level_count;
    assign found_pos   = pos_reg | PAGE_W'(wres.first_free);
    assign accept      = s_valid && s_ready;
    // take a new page count only between items
    assign cfg_ready   = state_reg == ST_IDLE;
    assign cfg_accept  = cfg_valid && cfg_ready;
    // hold off input until the geometry register has caught up
    assign cfg_wait_next = cfg_accept;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == IDX_W'(STORE_WORDS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_item.kind == KIND_ALLOC) begin
                        state_next = ST_SRCH_RD;
                    end else if ((s_item.kind == KIND_FREE || s_item.kind == KIND_RESERVE)
                                 && CNT_W'(s_item.page_number) < geom.eff_pages) begin
                        state_next = ST_MARK_RD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SRCH_RD: state_next = ST_SRCH_EV;
            ST_SRCH_EV: begin
                if (!wres.any_free) state_next = ST_DONE;
                else if (lvl_reg != '0) state_next = ST_SRCH_RD;
                else if (CNT_W'(found_pos) >= geom.eff_pages) state_next = ST_DONE;
                else state_next = ST_MARK_RD;
            end
            ST_MARK_RD: state_next = ST_MARK_WR;
            ST_MARK_WR: begin
                if (!set_mode_reg && lvl_reg != '0 && !wres.bit_set) state_next = ST_DONE;
                else if (set_mode_reg && !wres.set_full) state_next = ST_DONE;
                else if (last_lvl) state_next = ST_DONE;
                else state_next = ST_MARK_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // sequencer outputs: store port and input handshake
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = lvl_addr[IDX_W-1:0];
        mem_wdata = wres.set_word;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_idx_reg;
                mem_wdata = '1;
            end
            ST_IDLE:    s_ready = !cfg_valid && !cfg_wait_reg;
            ST_SRCH_RD,
            ST_MARK_RD: mem_re = lvl_addr_ok;
            ST_MARK_WR: begin
                mem_we    = lvl_addr_ok
                            && !(!set_mode_reg && lvl_reg != '0 && !wres.bit_set);
                mem_wdata = set_mode_reg ? wres.set_word : wres.clr_word;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        managed_pages_next = cfg_accept ? cfg_data : managed_pages_reg;
        clr_idx_next       = clr_idx_reg;
        lvl_next           = lvl_reg;
        pos_next           = pos_reg;
        set_mode_next      = set_mode_reg;
        res_status_next    = res_status_reg;
        res_page_next      = res_page_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_item_next        = m_item_reg;
        case (state_reg)
            ST_CLEAR: clr_idx_next = clr_idx_reg + IDX_W'(1);
            ST_IDLE: begin
                res_status_next = STATUS_OK;
                res_page_next   = '0;
                pos_next        = s_item.page_number;
                lvl_next        = '0;
                set_mode_next   = s_item.kind != KIND_FREE;
                if (s_item.kind == KIND_ALLOC) begin
                    pos_next = '0;
                    lvl_next = top_lvl;
                end else if ((s_item.kind == KIND_FREE || s_item.kind == KIND_RESERVE)
                             && CNT_W'(s_item.page_number) >= geom.eff_pages) begin
                    res_status_next = STATUS_RANGE;
                end
            end
            ST_SRCH_EV: begin
                if (!wres.any_free) begin
                    res_status_next = STATUS_NO_FREE;
                end else if (lvl_reg != '0) begin
                    // descend: the bit found selects the child word
                    pos_next = found_pos << BIT_SEL_W;
                    lvl_next = lvl_reg - LVL_W'(1);
                end else if (CNT_W'(found_pos) >= geom.eff_pages) begin
                    res_status_next = STATUS_NO_FREE;
                end else begin
                    pos_next      = found_pos;
                    res_page_next = found_pos;
                end
            end
            ST_MARK_WR: begin
                lvl_next = lvl_reg + LVL_W'(1);
                pos_next = pos_reg >> BIT_SEL_W;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_item_next.status  = res_status_reg;
                    m_item_next.granted_page = res_page_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            managed_pages_reg <= CNT_W'(MAX_PAGES);
            cfg_wait_reg      <= 1'b0;
            clr_idx_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            managed_pages_reg <= managed_pages_next;
            cfg_wait_reg      <= cfg_wait_next;
            clr_idx_reg       <= clr_idx_next;
            m_valid_reg       <= m_valid_next;
        end
        lvl_reg        <= lvl_next;
        pos_reg        <= pos_next;
        set_mode_reg   <= set_mode_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        m_item_reg     <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (mem_re) rd_data_reg <= mem[mem_addr];
        rd_oob_reg <= !lvl_addr_ok;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a failed item never reports a page
    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != STATUS_OK |-> m_item.granted_page == '0)
        else $error("nonzero granted_page on failed item");

    // one item at a time: no second accept right after the first
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // a new result is loaded only from the final sequencer state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the final state");

endmodule
